// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lfbd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS flag byte decoder package
// Shared widths, byte type and default history depth of the decoder.
// ----------------------------------------------------------------------------
package lfbd_pkg;

   localparam int BYTE_W            = 8;
   localparam int DIST_W            = 13;
   localparam int HISTORY_DEPTH_DEF = 4096;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

// ----- design/lzss_flag_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// LZSS flag byte decoder
// Decodes a flag-byte LZSS stream with a byte history window.
// ----------------------------------------------------------------------------
// One compressed byte enters per word on req_; decoded bytes leave on rsp_.
// Flag bytes, match high bytes and literals are taken while the output slot
// is free; bytes after the end marker are always taken and dropped. A match
// low byte starts the first history read; the match then copies one byte per
// cycle while the output slot is free (2 to 16), since each copied byte needs
// one read and one write of the history memory, and the input is held until
// the copy ends. The history needs no clearing pass: a write pointer and a
// wrap flag mark which entries were ever written; unwritten ones read as zero.
module lzss_flag_byte_decoder #(
   parameter int HISTORY_DEPTH = lfbd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lfbd_pkg::byte_type   req_tdata,    // [7:0] in_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lfbd_pkg::byte_type   rsp_tdata,    // [7:0] out_byte
   output logic                 rsp_tlast,
   output logic                 rsp_tuser     // [0] stream_end
);
   import lfbd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   localparam logic [1:0] ST_FLAG  = 2'd0;
   localparam logic [1:0] ST_TOKEN = 2'd1;
   localparam logic [1:0] ST_LOW   = 2'd2;
   localparam logic [1:0] ST_COPY  = 2'd3;

   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (p == LAST_ADDR) ? '0 : p + AW'(1);
      return r;
   endfunction

   logic [1:0]    state_ff, state_in;
   byte_type      flag_ff, flag_in;
   logic [3:0]    tokens_ff, tokens_in;
   byte_type      high_ff, high_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;
   logic          finished_ff, finished_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          hit_ff, hit_in;
   byte_type      fwd_ff, fwd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   byte_type      rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_end_ff, rsp_end_in;

   logic                slot_free;
   logic                req_fire;
   logic                take;
   logic [2*BYTE_W-1:0] word;
   logic [DIST_W-1:0]   match_dist;
   logic [AW:0]         diff;
   logic [AW:0]         diff_wrap;
   logic [AW-1:0]       src0;
   logic [AW-1:0]       rd_next;
   byte_type            copy_val;
   byte_type            ram_q;
   logic                ram_we;
   byte_type            ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic                emit;
   byte_type            emit_byte;
   logic                emit_last;
   logic                emit_end;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = finished_ff || ((state_ff != ST_COPY) && slot_free);
   assign req_fire   = req_tvalid && req_tready;
   assign take       = req_fire && !finished_ff;

   assign word       = {high_ff, req_tdata};
   assign match_dist = {1'b0, word[2*BYTE_W-1:4]} + DIST_W'(1);
   assign diff       = {1'b0, wp_ff} - (AW+1)'(match_dist);
   assign diff_wrap  = diff + (AW+1)'(HISTORY_DEPTH);
   assign src0       = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
   assign rd_next    = ptr_inc(rd_addr_ff);
   assign copy_val   = !rd_ok_ff ? '0 : (hit_ff ? fwd_ff : ram_q);

   always_comb begin
      state_in    = state_ff;
      flag_in     = flag_ff;
      tokens_in   = tokens_ff;
      high_in     = high_ff;
      finished_in = finished_ff;
      cnt_in      = cnt_ff;
      rd_addr_in  = rd_addr_ff;
      rd_ok_in    = rd_ok_ff;
      hit_in      = hit_ff;
      fwd_in      = fwd_ff;
      ram_we      = 1'b0;
      ram_wdata   = req_tdata;
      ram_re      = 1'b0;
      ram_raddr   = src0;
      emit        = 1'b0;
      emit_byte   = req_tdata;
      emit_last   = 1'b1;
      emit_end    = 1'b0;

      unique case (state_ff)
         ST_FLAG: begin
            if (take) begin
               flag_in   = req_tdata;
               tokens_in = 4'd8;
               state_in  = ST_TOKEN;
            end
         end
         ST_TOKEN: begin
            if (take) begin
               if (flag_ff[0]) begin
                  high_in  = req_tdata;
                  state_in = ST_LOW;
               end else begin
                  ram_we    = 1'b1;
                  emit      = 1'b1;
                  flag_in   = flag_ff >> 1;
                  tokens_in = tokens_ff - 4'd1;
                  state_in  = (tokens_ff == 4'd1) ? ST_FLAG : ST_TOKEN;
               end
            end
         end
         ST_LOW: begin
            if (take) begin
               if (req_tdata[3:0] == 4'd0) begin
                  finished_in = 1'b1;
                  emit        = 1'b1;
                  emit_byte   = '0;
                  emit_end    = 1'b1;
               end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = src0;
                  rd_addr_in = src0;
                  rd_ok_in   = wrapped_ff || (src0 < wp_ff);
                  hit_in     = 1'b0;
                  cnt_in     = req_tdata[3:0];
                  state_in   = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (slot_free) begin
               ram_we    = 1'b1;
               ram_wdata = copy_val;
               emit      = 1'b1;
               emit_byte = copy_val;
               emit_last = (cnt_ff == 4'd0);
               if (cnt_ff == 4'd0) begin
                  flag_in   = flag_ff >> 1;
                  tokens_in = tokens_ff - 4'd1;
                  state_in  = (tokens_ff == 4'd1) ? ST_FLAG : ST_TOKEN;
               end else begin
                  cnt_in     = cnt_ff - 4'd1;
                  ram_re     = 1'b1;
                  ram_raddr  = rd_next;
                  rd_addr_in = rd_next;
                  rd_ok_in   = wrapped_ff || (rd_next <= wp_ff);
                  hit_in     = (rd_next == wp_ff);
                  fwd_in     = copy_val;
               end
            end
         end
         default: begin
            state_in = ST_FLAG;
         end
      endcase
   end

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (ram_we) begin
         wp_in = ptr_inc(wp_ff);
         if (wp_ff == LAST_ADDR) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_end_in   = emit_end;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FLAG;
         flag_ff      <= '0;
         tokens_ff    <= '0;
         high_ff      <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         tokens_ff    <= tokens_in;
         high_ff      <= high_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rd_addr_ff  <= rd_addr_in;
      rd_ok_ff    <= rd_ok_in;
      hit_ff      <= hit_in;
      fwd_ff      <= fwd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   lfbd_hist_ram #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

endmodule

// ----- design/lfbd_hist_ram.sv -----
// ----------------------------------------------------------------------------
// LZSS history memory
// Single-write, single-read byte memory with a registered read port.
// ----------------------------------------------------------------------------
module lfbd_hist_ram #(
   parameter int HISTORY_DEPTH = lfbd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(HISTORY_DEPTH)-1:0]   wr_addr,
   input  lfbd_pkg::byte_type                 wr_data,
   input  logic                               rd_en,
   input  logic [$clog2(HISTORY_DEPTH)-1:0]   rd_addr,
   output lfbd_pkg::byte_type                 rd_data
);
   import lfbd_pkg::*;

   byte_type mem_ff [HISTORY_DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lfbd_checker.sv -----
// ----------------------------------------------------------------------------
// LZSS flag byte decoder checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfbd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input lfbd_pkg::byte_type   rsp_tdata,
   input logic                 rsp_tlast,
   input logic                 rsp_tuser
);
   import lfbd_pkg::*;

   logic              rsp_fire;
   logic              rsp_stall;
   logic              end_shown;
   logic              end_form_ok;
   logic [BYTE_W+1:0] rsp_word;

   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign end_shown   = rsp_tvalid && rsp_tuser;
   assign end_form_ok = rsp_tlast && (rsp_tdata == byte_type'(0));
   assign rsp_word    = {rsp_tuser, rsp_tlast, rsp_tdata};

   `ASSERT_CLK(a_end_word_form, clock, reset, !end_shown || end_form_ok, "end word not last zero")
   `ASSERT_CLK(a_end_drops_input, clock, reset, !end_shown || req_tready, "input held after end")
   `ASSERT_NEXT(a_nothing_after_end, clock, reset, rsp_fire && rsp_tuser, !rsp_tvalid, "word after end")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word), "word not held")

endmodule

bind lzss_flag_byte_decoder lfbd_checker u_lfbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
